/* design/crcfs_pkg.sv */
// ----------------------------------------------------------------------------
// CRC16 frame slave responder package
// Shared constants, reply kinds, register indexes and the byte-wise CRC16
// update used by the frame receiver and the reply generator.
// ----------------------------------------------------------------------------
package crcfs_pkg;

  // Default frame length in bytes, including the two CRC bytes.
  localparam int FRAME_BYTES_DEF = 20;

  // CRC16-MODBUS constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Fixed reply contents.
  localparam logic [7:0] REPLY_ADDR  = 8'h00;
  localparam logic [7:0] ID_VALUE    = 8'h64;
  localparam logic [7:0] TEMP_LOW    = 8'hFE;
  localparam logic [7:0] TEMP_HIGH   = 8'h0C;
  localparam logic [7:0] PAYLOAD_PAD = 8'h00;

  // Register reset values.
  localparam logic [7:0] RST_BROADCAST  = 8'd255;
  localparam logic [7:0] RST_ADDR_MIN   = 8'd1;
  localparam logic [7:0] RST_ADDR_MAX   = 8'd32;
  localparam logic [7:0] RST_START     = 8'd1;
  localparam logic [7:0] RST_CODE_SET   = 8'd16;
  localparam logic [7:0] RST_CODE_ID    = 8'd1;
  localparam logic [7:0] RST_CODE_MOTOR = 8'd2;
  localparam logic [7:0] RST_CODE_TEMP  = 8'd3;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    REG_BROADCAST  = 8'd0,
    REG_ADDR_MIN   = 8'd1,
    REG_ADDR_MAX   = 8'd2,
    REG_START      = 8'd3,
    REG_CODE_SET   = 8'd4,
    REG_CODE_ID    = 8'd5,
    REG_CODE_MOTOR = 8'd6,
    REG_CODE_TEMP  = 8'd7
  } cfg_reg_t;

  // Kind of payload carried by a reply.
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_GET_ID,
    KIND_READ_TEMP
  } reply_kind_t;

  // Request from the frame receiver to start a reply.
  typedef struct packed {
    logic        valid;
    reply_kind_t kind;
    logic [7:0]  command;
  } reply_launch_t;

  // One byte step of the reflected CRC16 (poly 0xA001).
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/crc16_frame_slave_responder.sv */
// ----------------------------------------------------------------------------
// CRC16 frame slave responder
// Groups received bytes into fixed frames, checks their CRC16-MODBUS and
// answers addressed frames with a fixed-length reply frame.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one received byte per item; the out_ channel
//   carries one reply byte per item, with out_tx_last on the final byte.
//   Both channels move an item when valid is high and stall is low.
//   Received bytes are taken one per cycle while in_stall is low. The frame
//   is judged when its last byte is accepted and the reply sequencer starts
//   on that edge; the sequencer then loads the first reply byte into the
//   output register. The reply streams at one byte per cycle while out_stall
//   is low, FRAME_BYTES in all.
//   Only the final byte of a frame can be held off: in_stall rises on it
//   while the previous reply is still being sent, which is set by the
//   single reply sequencer. Outside that, throughput is one item per cycle.
//   A receiver stall holds the output register and pauses the reply.
//   The cfg_ port writes a register by index (cfg_ready is always high);
//   writes beyond the register list are ignored.
//   After reset the frame position is zero, the registers hold their
//   defaults and the own address equals the start address.
// ----------------------------------------------------------------------------
module crc16_frame_slave_responder
  import crcfs_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] LO_POS   = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_BYTES - 1);

  // Configuration registers.
  logic [7:0] bcast_r, addr_min_r, addr_max_r;
  logic [7:0] code_set_r, code_id_r, code_temp_r;

  // Frame receiver state.
  logic [CNT_W-1:0] count_r;
  logic [15:0]      crc_r;
  logic [7:0]       addr_r, cmd_r, data0_r, crc_lo_r;
  logic [7:0]       own_r;

  logic          in_acc;
  logic          finish;
  logic          crc_ok;
  logic          is_set_addr;
  logic          in_range;
  logic          addressed;
  logic          gen_free;
  reply_launch_t launch;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count_r == LAST_POS) && !gen_free;
  assign in_acc    = in_valid && !in_stall;
  assign finish    = in_acc && (count_r == LAST_POS);

  // Frame decisions on the last byte.
  assign crc_ok      = ({in_rx_byte, crc_lo_r} == crc_r);
  assign is_set_addr = (cmd_r == code_set_r) && (addr_r == bcast_r);
  assign in_range    = (data0_r >= addr_min_r) && (data0_r <= addr_max_r);
  assign addressed   = (addr_r == bcast_r) || (addr_r == own_r);

  always_comb begin
    launch.valid   = finish && crc_ok && !is_set_addr && addressed;
    launch.command = cmd_r;
    if (cmd_r == code_id_r) begin
      launch.kind = KIND_GET_ID;
    end else if (cmd_r == code_temp_r) begin
      launch.kind = KIND_READ_TEMP;
    end else begin
      launch.kind = KIND_ZERO;
    end
  end

  // Configuration writes. The start address only loads the own address, and
  // the motor-poll code needs no register because that command gets the
  // zero payload like any unmatched one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcast_r      <= RST_BROADCAST;
      addr_min_r   <= RST_ADDR_MIN;
      addr_max_r   <= RST_ADDR_MAX;
      code_set_r   <= RST_CODE_SET;
      code_id_r    <= RST_CODE_ID;
      code_temp_r  <= RST_CODE_TEMP;
      own_r        <= RST_START;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BROADCAST:  bcast_r <= cfg_wdata;
        REG_ADDR_MIN:   addr_min_r <= cfg_wdata;
        REG_ADDR_MAX:   addr_max_r <= cfg_wdata;
        REG_START:      own_r <= cfg_wdata;
        REG_CODE_SET:   code_set_r <= cfg_wdata;
        REG_CODE_ID:    code_id_r <= cfg_wdata;
        REG_CODE_MOTOR: ;
        REG_CODE_TEMP:  code_temp_r <= cfg_wdata;
        default: ;
      endcase
    end else if (finish && crc_ok && is_set_addr && in_range) begin
      own_r <= data0_r;
    end
  end

  // Frame position and running CRC.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
    end else if (in_acc) begin
      if (count_r < LO_POS) begin
        crc_r   <= crc16_update(crc_r, in_rx_byte);
        count_r <= count_r + CNT_W'(1);
      end else if (count_r == LO_POS) begin
        count_r <= count_r + CNT_W'(1);
      end else begin
        count_r <= '0;
        crc_r   <= CRC_INIT;
      end
    end
  end

  // Header bytes and the received CRC low byte.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (count_r == CNT_W'(0)) begin
        addr_r <= in_rx_byte;
      end
      if (count_r == CNT_W'(1)) begin
        cmd_r <= in_rx_byte;
      end
      if (count_r == CNT_W'(2)) begin
        data0_r <= in_rx_byte;
      end
      if (count_r == LO_POS) begin
        crc_lo_r <= in_rx_byte;
      end
    end
  end

  // Reply sequencer and output register.
  crcfs_reply_gen #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_reply_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .launch     (launch),
    .gen_free   (gen_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_tx_byte(out_tx_byte),
    .out_tx_last(out_tx_last)
  );

  // The frame position never runs past the last byte.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= LAST_POS)
    else $error("frame position out of range");

  // A reply is only started when the sequencer can take it.
  assert property (@(posedge clk) disable iff (!rst_n) launch.valid |-> gen_free)
    else $error("reply started while sequencer busy");

  // Input is held off only on the final byte of a frame.
  assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> count_r == LAST_POS)
    else $error("input stalled away from frame end");

  // A reply started while the output is empty brings its first byte to the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    launch.valid && !out_valid |-> ##2 (out_valid && !out_tx_last))
    else $error("reply did not start");

endmodule

/* design/crcfs_reply_gen.sv */
// ----------------------------------------------------------------------------
// Reply generator
// Streams one reply frame, a byte per cycle unless out_stall holds it, into
// an output register; payload per reply kind, then own CRC16, low byte first.
// ----------------------------------------------------------------------------
module crcfs_reply_gen
  import crcfs_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  reply_launch_t launch,
  output logic          gen_free,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_tx_byte,
  output logic          out_tx_last
);

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] BODY_POS = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] HIGH_POS = CNT_W'(FRAME_BYTES - 1);

  logic             active_r;
  logic [CNT_W-1:0] idx_r;
  logic [15:0]      crc_r;
  reply_kind_t      kind_r;
  logic [7:0]       cmd_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic             load;
  logic [7:0]       byte_nxt;

  // A byte moves into the output register when it is empty or being taken.
  assign load     = active_r && (!out_valid_r || !out_stall);
  assign gen_free = !active_r || (load && (idx_r == HIGH_POS));

  // Byte at the current reply position.
  always_comb begin
    if (idx_r == BODY_POS) begin
      byte_nxt = crc_r[7:0];
    end else if (idx_r == HIGH_POS) begin
      byte_nxt = crc_r[15:8];
    end else if (idx_r == CNT_W'(0)) begin
      byte_nxt = REPLY_ADDR;
    end else if (idx_r == CNT_W'(1)) begin
      byte_nxt = cmd_r;
    end else if (idx_r == CNT_W'(2) && kind_r == KIND_READ_TEMP) begin
      byte_nxt = TEMP_LOW;
    end else if (idx_r == CNT_W'(3) && kind_r == KIND_READ_TEMP) begin
      byte_nxt = TEMP_HIGH;
    end else if (idx_r == CNT_W'(3) && kind_r == KIND_GET_ID) begin
      byte_nxt = ID_VALUE;
    end else begin
      byte_nxt = PAYLOAD_PAD;
    end
  end

  // Sequencer state and running reply CRC.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (launch.valid) begin
      active_r <= 1'b1;
    end else if (load && idx_r == HIGH_POS) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (launch.valid) begin
      idx_r  <= '0;
      crc_r  <= CRC_INIT;
      kind_r <= launch.kind;
      cmd_r  <= launch.command;
    end else if (load) begin
      idx_r <= idx_r + CNT_W'(1);
      if (idx_r < BODY_POS) begin
        crc_r <= crc16_update(crc_r, byte_nxt);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_nxt;
      out_last_r <= (idx_r == HIGH_POS);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_byte_r;
  assign out_tx_last = out_last_r;

endmodule
